/* rtl/core/pdmf_pkg.sv */
`timescale 1ns / 1ps

package pdmf_pkg;

	// Ring depth and derived widths
	localparam int WINDOW = 8;
	localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);

	// Field widths
	localparam int TS_W      = 64;
	localparam int TIME_W    = 32;
	localparam int DELAY_W   = 63;
	// A stored sample is a non-negative 64-bit value halved: 62 bits of magnitude
	localparam int SAMPLE_W  = 62;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PEER_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE   = 1'd1;

	localparam logic [TIME_W-1:0] MAX_AGE_RESET = 32'd16000;

	// Timestamps of one exchange
	typedef struct packed {
		logic [TS_W-1:0] t1;
		logic [TS_W-1:0] t2;
		logic [TS_W-1:0] t3;
		logic [TS_W-1:0] t4;
		logic [TS_W-1:0] t5;
		logic [TS_W-1:0] t6;
	} stamps_t;

	// One ring entry
	typedef struct packed {
		logic [TIME_W-1:0]   stamp;
		logic [SAMPLE_W-1:0] sample;
	} entry_t;

	// Operations of the shared subtractor
	typedef enum logic [1:0] {
		ALU_DIFF_A,
		ALU_DIFF_B,
		ALU_NUM,
		ALU_AGE
	} alu_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF_A,
		ST_DIFF_B,
		ST_NUM,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

/* rtl/core/ptp_path_delay_min_filter.sv */
`timescale 1ns / 1ps
// Steps per request: DIFF_A, DIFF_B, NUM, then SCAN over the N stored entries (1..WINDOW),
//   then DONE; a rejected (negative) sample skips SCAN. DONE waits for a free output register.
// One request at a time: in_ready is high only in IDLE, so the pace is set by the shared
//   64-bit subtractor (three delay steps, one age per entry) and the single ring read port.
// Reset (arst_n low): registers to defaults, ring empty, held delay 0; ring data is not cleared.
module ptp_path_delay_min_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pdmf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pdmf_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [pdmf_pkg::TS_W-1:0]      req_sent_local,
	input  logic signed [pdmf_pkg::TS_W-1:0]      req_recv_remote,
	input  logic signed [pdmf_pkg::TS_W-1:0]      resp_sent_remote,
	input  logic signed [pdmf_pkg::TS_W-1:0]      resp_recv_local,
	input  logic signed [pdmf_pkg::TS_W-1:0]      sync_sent_master,
	input  logic signed [pdmf_pkg::TS_W-1:0]      sync_recv_local,
	input  logic [pdmf_pkg::TIME_W-1:0]           now_ms,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  accepted,
	output logic [pdmf_pkg::DELAY_W-1:0]          path_delay,
	output logic                                  delay_valid
);

	// Configuration
	logic                               peer_mode_q;
	logic [pdmf_pkg::TIME_W-1:0]        max_age_q;

	// Sequencer
	pdmf_pkg::state_t                   state_q;
	pdmf_pkg::state_t                   state_nxt;
	pdmf_pkg::alu_op_t                  alu_op;
	logic                               wr_en;
	logic                               rd_en;
	logic                               load_out;

	// Captured request and intermediate differences
	pdmf_pkg::stamps_t                  stamps_q;
	logic [pdmf_pkg::TIME_W-1:0]        now_q;
	logic [pdmf_pkg::TS_W-1:0]          diff_a_q;
	logic [pdmf_pkg::TS_W-1:0]          diff_b_q;
	logic [pdmf_pkg::TS_W-1:0]          alu_result;
	logic                               reject;
	logic [pdmf_pkg::SAMPLE_W-1:0]      sample_new;
	logic                               take_q;

	// Ring bookkeeping
	logic [pdmf_pkg::ADDR_W-1:0]        wp_q;
	logic [pdmf_pkg::CNT_W-1:0]         count_q;
	logic [pdmf_pkg::CNT_W-1:0]         scan_idx_q;
	pdmf_pkg::entry_t                   wr_entry;
	pdmf_pkg::entry_t                   rd_entry;

	// Scan state
	logic                               rd_vld_s1;
	logic                               rd_first_s1;
	logic [pdmf_pkg::TIME_W-1:0]        age;
	logic                               stale;
	logic                               have_q;
	logic [pdmf_pkg::SAMPLE_W-1:0]      best_q;
	logic [pdmf_pkg::SAMPLE_W-1:0]      newest_q;
	logic [pdmf_pkg::TIME_W-1:0]        newest_age_q;
	logic [pdmf_pkg::SAMPLE_W-1:0]      final_delay;

	// Held result and output register
	logic [pdmf_pkg::SAMPLE_W-1:0]      held_q;
	logic                               valid_flag_q;
	logic                               out_valid_q;
	logic                               out_accepted_q;
	logic [pdmf_pkg::DELAY_W-1:0]       out_delay_q;
	logic                               out_dvalid_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_mode_q <= 1'b0;
			max_age_q   <= pdmf_pkg::MAX_AGE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdmf_pkg::REG_PEER_MODE: peer_mode_q <= cfg_data[0];
				pdmf_pkg::REG_MAX_AGE:   max_age_q   <= cfg_data[pdmf_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared subtractor
	pdmf_alu u_alu (
		.op         (alu_op),
		.peer_mode  (peer_mode_q),
		.stamps     (stamps_q),
		.diff_a     (diff_a_q),
		.diff_b     (diff_b_q),
		.now        (now_q),
		.entry_time (rd_entry.stamp),
		.result     (alu_result)
	);

	// Halving toward zero: only -1 rounds up to an accepted zero
	assign reject     = alu_result[pdmf_pkg::TS_W-1] & ~(&alu_result[pdmf_pkg::TS_W-2:0]);
	assign sample_new = alu_result[pdmf_pkg::TS_W-1] ? '0
	                  : alu_result[pdmf_pkg::SAMPLE_W:1];

	assign wr_entry.stamp  = now_q;
	assign wr_entry.sample = sample_new;

	pdmf_ring u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (scan_idx_q[pdmf_pkg::ADDR_W-1:0]),
		.rd_data (rd_entry)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pdmf_pkg::ST_IDLE:   if (in_valid) state_nxt = pdmf_pkg::ST_DIFF_A;
			pdmf_pkg::ST_DIFF_A: state_nxt = pdmf_pkg::ST_DIFF_B;
			pdmf_pkg::ST_DIFF_B: state_nxt = pdmf_pkg::ST_NUM;
			pdmf_pkg::ST_NUM:    state_nxt = reject ? pdmf_pkg::ST_DONE : pdmf_pkg::ST_SCAN;
			pdmf_pkg::ST_SCAN:   if (!rd_en && !rd_vld_s1) state_nxt = pdmf_pkg::ST_DONE;
			pdmf_pkg::ST_DONE:   if (load_out) state_nxt = pdmf_pkg::ST_IDLE;
			default:             state_nxt = pdmf_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = 1'b0;
		alu_op   = pdmf_pkg::ALU_AGE;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			pdmf_pkg::ST_IDLE:   in_ready = 1'b1;
			pdmf_pkg::ST_DIFF_A: alu_op = pdmf_pkg::ALU_DIFF_A;
			pdmf_pkg::ST_DIFF_B: alu_op = pdmf_pkg::ALU_DIFF_B;
			pdmf_pkg::ST_NUM: begin
				alu_op = pdmf_pkg::ALU_NUM;
				wr_en  = ~reject;
			end
			pdmf_pkg::ST_SCAN:   rd_en = (scan_idx_q < count_q);
			pdmf_pkg::ST_DONE:   load_out = ~out_valid_q | out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdmf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Request capture and difference registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			stamps_q.t1 <= sync_sent_master;
			stamps_q.t2 <= sync_recv_local;
			stamps_q.t3 <= req_sent_local;
			stamps_q.t4 <= req_recv_remote;
			stamps_q.t5 <= resp_sent_remote;
			stamps_q.t6 <= resp_recv_local;
			now_q       <= now_ms;
		end
		if (state_q == pdmf_pkg::ST_DIFF_A) begin
			diff_a_q <= alu_result;
		end
		if (state_q == pdmf_pkg::ST_DIFF_B) begin
			diff_b_q <= alu_result;
		end
	end

	// Ring pointer, fill count, scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			count_q     <= '0;
			scan_idx_q  <= '0;
			take_q      <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
		end else begin
			rd_vld_s1   <= rd_en;
			rd_first_s1 <= rd_en && (scan_idx_q == '0);
			if (state_q == pdmf_pkg::ST_NUM) begin
				take_q     <= ~reject;
				scan_idx_q <= '0;
			end else if (rd_en) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (wr_en) begin
				wp_q <= (wp_q == pdmf_pkg::ADDR_W'(pdmf_pkg::WINDOW - 1)) ? '0 : wp_q + 1'b1;
				if (count_q != pdmf_pkg::CNT_W'(pdmf_pkg::WINDOW)) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// Scan: newest entry and fresh minimum, one entry a cycle
	assign age   = alu_result[pdmf_pkg::TIME_W-1:0];
	assign stale = age > max_age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (state_q == pdmf_pkg::ST_NUM) begin
			have_q <= 1'b0;
		end else if (rd_vld_s1 && !stale) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (rd_first_s1 || (age < newest_age_q)) begin
				newest_q     <= rd_entry.sample;
				newest_age_q <= age;
			end
			if (!stale && (!have_q || (rd_entry.sample < best_q))) begin
				best_q <= rd_entry.sample;
			end
		end
	end

	assign final_delay = have_q ? best_q : newest_q;

	// Held delay and valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			valid_flag_q <= 1'b0;
		end else if (load_out && take_q) begin
			held_q       <= final_delay;
			valid_flag_q <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_accepted_q <= take_q;
			out_delay_q    <= {{(pdmf_pkg::DELAY_W - pdmf_pkg::SAMPLE_W){1'b0}},
			                   (take_q ? final_delay : held_q)};
			out_dvalid_q   <= valid_flag_q | take_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = out_accepted_q;
	assign path_delay  = out_delay_q;
	assign delay_valid = out_dvalid_q;

endmodule

/* rtl/core/pdmf_alu.sv */
`timescale 1ns / 1ps

// Shared 64-bit subtractor with operand selection per sequencer step
module pdmf_alu (
	input  pdmf_pkg::alu_op_t            op,
	input  logic                         peer_mode,
	input  pdmf_pkg::stamps_t            stamps,
	input  logic [pdmf_pkg::TS_W-1:0]    diff_a,
	input  logic [pdmf_pkg::TS_W-1:0]    diff_b,
	input  logic [pdmf_pkg::TIME_W-1:0]  now,
	input  logic [pdmf_pkg::TIME_W-1:0]  entry_time,
	output logic [pdmf_pkg::TS_W-1:0]    result
);

	logic [pdmf_pkg::TS_W-1:0] opa;
	logic [pdmf_pkg::TS_W-1:0] opb;

	// Operand mux
	always_comb begin
		unique case (op)
			pdmf_pkg::ALU_DIFF_A: begin
				// peer: t6 - t3, end to end: t4 - t1
				opa = peer_mode ? stamps.t6 : stamps.t4;
				opb = peer_mode ? stamps.t3 : stamps.t1;
			end
			pdmf_pkg::ALU_DIFF_B: begin
				// peer: t5 - t4, end to end: t3 - t2
				opa = peer_mode ? stamps.t5 : stamps.t3;
				opb = peer_mode ? stamps.t4 : stamps.t2;
			end
			pdmf_pkg::ALU_NUM: begin
				opa = diff_a;
				opb = diff_b;
			end
			pdmf_pkg::ALU_AGE: begin
				opa = {{(pdmf_pkg::TS_W - pdmf_pkg::TIME_W){1'b0}}, now};
				opb = {{(pdmf_pkg::TS_W - pdmf_pkg::TIME_W){1'b0}}, entry_time};
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign result = opa - opb;

endmodule

/* rtl/core/pdmf_ring.sv */
`timescale 1ns / 1ps

// Sample ring: one write and one registered read per cycle
module pdmf_ring (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [pdmf_pkg::ADDR_W-1:0]   wr_addr,
	input  pdmf_pkg::entry_t              wr_data,
	input  logic                          rd_en,
	input  logic [pdmf_pkg::ADDR_W-1:0]   rd_addr,
	output pdmf_pkg::entry_t              rd_data
);

	pdmf_pkg::entry_t mem_q [pdmf_pkg::WINDOW];
	pdmf_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/core/pdmf_checker.sv */
`timescale 1ns / 1ps

module pdmf_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic                                  accepted,
	input  logic [pdmf_pkg::DELAY_W-1:0]          path_delay,
	input  logic                                  delay_valid
);

	// One request at a time: busy right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high the cycle after a request was accepted");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(path_delay) && $stable(accepted)))
		else $error("result changed while stalled");

	// A stored sample always marks the delay valid
	a_accept_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> delay_valid)
		else $error("accepted result without delay_valid");

	// Once valid, the delay stays valid
	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && delay_valid) |=> delay_valid)
		else $error("delay_valid dropped");

	// Before any sample is stored the held delay is zero
	a_zero_before_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !delay_valid) |-> (path_delay == '0))
		else $error("nonzero delay before any sample was stored");

endmodule

bind ptp_path_delay_min_filter pdmf_checker u_pdmf_checker (.*);

/* bench/tb_ptp_path_delay_min_filter.sv */
`timescale 1ns / 1ps

module tb_ptp_path_delay_min_filter;

	localparam int          LONG_HOLD   = 400;   // receiver hold-off for the pressure test
	localparam int          QUIET_LIMIT = 5000;  // cycles with no handshake before giving up
	localparam int          END_CYCLES  = 40;    // settle time after the last result
	localparam logic [63:0] S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN     = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

	// One delay exchange as presented on the request side
	typedef struct {
		logic [63:0] t1;
		logic [63:0] t2;
		logic [63:0] t3;
		logic [63:0] t4;
		logic [63:0] t5;
		logic [63:0] t6;
		logic [31:0] now;
	} exchange_t;

	// One filter report as seen on the result side
	typedef struct {
		logic                         accepted;
		logic [pdmf_pkg::DELAY_W-1:0] path_delay;
		logic                         delay_valid;
	} delay_report_t;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  cfg_we;
	logic [pdmf_pkg::CFG_IDX_W-1:0]        cfg_index;
	logic [pdmf_pkg::CFG_W-1:0]            cfg_data;
	logic                                  in_valid;
	logic                                  in_ready;
	logic signed [pdmf_pkg::TS_W-1:0]      req_sent_local;
	logic signed [pdmf_pkg::TS_W-1:0]      req_recv_remote;
	logic signed [pdmf_pkg::TS_W-1:0]      resp_sent_remote;
	logic signed [pdmf_pkg::TS_W-1:0]      resp_recv_local;
	logic signed [pdmf_pkg::TS_W-1:0]      sync_sent_master;
	logic signed [pdmf_pkg::TS_W-1:0]      sync_recv_local;
	logic [pdmf_pkg::TIME_W-1:0]           now_ms;
	logic                                  out_valid;
	logic                                  out_ready;
	logic                                  accepted;
	logic [pdmf_pkg::DELAY_W-1:0]          path_delay;
	logic                                  delay_valid;

	ptp_path_delay_min_filter uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_sent_local   (req_sent_local),
		.req_recv_remote  (req_recv_remote),
		.resp_sent_remote (resp_sent_remote),
		.resp_recv_local  (resp_recv_local),
		.sync_sent_master (sync_sent_master),
		.sync_recv_local  (sync_recv_local),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.accepted         (accepted),
		.path_delay       (path_delay),
		.delay_valid      (delay_valid)
	);

	// Clock: 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Filter state mirror
	logic [63:0]  ring_delay [pdmf_pkg::WINDOW];
	logic [31:0]  ring_ms [pdmf_pkg::WINDOW];
	int unsigned  ring_wr;
	int unsigned  ring_fill;
	logic [63:0]  filt_delay;
	bit           filt_valid;
	bit           mdl_peer;
	logic [31:0]  mdl_max_age;

	delay_report_t delay_reports_q [$];

	int unsigned errors;
	int unsigned reqs_sent;
	int unsigned reqs_stored;
	int unsigned reqs_rejected;
	int unsigned reports_seen;
	int unsigned reg_writes;
	int unsigned burst_left;
	bit          gaps_off;
	logic [31:0] cur_ms;
	int unsigned hold_token;

	// Apply one exchange to the mirror and form the report it should produce
	function automatic void filter_update(input exchange_t x, output delay_report_t r);
		logic [63:0] num;
		logic [63:0] mag;
		logic [63:0] samp;
		logic [63:0] best;
		logic [63:0] newest;
		logic [31:0] age;
		logic [31:0] newest_age;
		bit          neg;
		bit          have;
		if (mdl_peer)
			num = (x.t6 - x.t3) - (x.t5 - x.t4);
		else
			num = (x.t4 - x.t1) - (x.t3 - x.t2);
		// halve toward zero; -1 collapses to 0 and is kept
		if (num[63]) begin
			mag  = (~num + 64'd1) >> 1;
			neg  = (mag != 64'd0);
			samp = ~mag + 64'd1;
		end else begin
			neg  = 1'b0;
			samp = num >> 1;
		end
		if (!neg) begin
			ring_delay[ring_wr] = samp;
			ring_ms[ring_wr]    = x.now;
			ring_wr             = (ring_wr + 1) % pdmf_pkg::WINDOW;
			if (ring_fill < pdmf_pkg::WINDOW)
				ring_fill++;
			// minimum over fresh entries, newest entry as fallback
			have       = 1'b0;
			best       = 64'd0;
			newest     = ring_delay[0];
			newest_age = x.now - ring_ms[0];
			for (int i = 0; i < ring_fill; i++) begin
				age = x.now - ring_ms[i];
				if (age < newest_age) begin
					newest     = ring_delay[i];
					newest_age = age;
				end
				if (age <= mdl_max_age && (!have || ring_delay[i] < best)) begin
					best = ring_delay[i];
					have = 1'b1;
				end
			end
			filt_delay = have ? best : newest;
			filt_valid = 1'b1;
		end
		r.accepted    = !neg;
		r.path_delay  = filt_delay[pdmf_pkg::DELAY_W-1:0];
		r.delay_valid = filt_valid;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic exchange_t stamps(input logic [63:0] t3, input logic [63:0] t4,
			input logic [63:0] t5, input logic [63:0] t6, input logic [63:0] t1,
			input logic [63:0] t2, input logic [31:0] now);
		exchange_t x;
		x.t1  = t1;
		x.t2  = t2;
		x.t3  = t3;
		x.t4  = t4;
		x.t5  = t5;
		x.t6  = t6;
		x.now = now;
		return x;
	endfunction

	// Well-formed exchange whose numerator under the current formula is num
	function automatic exchange_t make_exchange(input logic [63:0] num, input logic [31:0] now);
		exchange_t x;
		x = stamps(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), now);
		if (mdl_peer) begin
			if ($urandom_range(0, 1))
				x.t5 = x.t4 + 64'($urandom_range(0, 100000));
			x.t6 = x.t3 + (x.t5 - x.t4) + num;
		end else begin
			x.t4 = x.t1 + (x.t3 - x.t2) + num;
		end
		return x;
	endfunction

	// Numerator mix: plausible delays half the time, plus the corners of the halving
	function automatic logic [63:0] pick_numerator();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 64'($urandom_range(0, 2000000));
		else if (r < 58)
			return 64'($urandom_range(0, 2)) - 64'd1;
		else if (r < 68)
			return 64'd0 - 64'($urandom_range(2, 5000));
		else if (r < 78)
			return S64_MAX - 64'($urandom_range(0, 1000));
		else if (r < 88)
			return S64_MIN + 64'($urandom_range(0, 1000));
		else
			return rnd64();
	endfunction

	// Millisecond clock walk: small steps, repeats, age boundary, backward and far jumps
	function automatic logic [31:0] next_ms(input int unsigned scale);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			cur_ms = cur_ms + $urandom_range(0, scale);
		else if (r < 65)
			cur_ms = cur_ms;
		else if (r < 75)
			cur_ms = cur_ms + mdl_max_age;
		else if (r < 80)
			cur_ms = cur_ms + mdl_max_age + 32'd1;
		else if (r < 90)
			cur_ms = cur_ms - $urandom_range(1, scale);
		else
			cur_ms = $urandom();
		return cur_ms;
	endfunction

	// Offer one request; bursts of random length separated by random gaps
	task automatic send_exchange(input exchange_t x);
		delay_report_t r;
		int unsigned   gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (gaps_off || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid         <= 1'b1;
		sync_sent_master <= x.t1;
		sync_recv_local  <= x.t2;
		req_sent_local   <= x.t3;
		req_recv_remote  <= x.t4;
		resp_sent_remote <= x.t5;
		resp_recv_local  <= x.t6;
		now_ms           <= x.now;
		do
			@(posedge clk);
		while (!in_ready);
		filter_update(x, r);
		delay_reports_q.push_back(r);
		reqs_sent++;
		if (r.accepted)
			reqs_stored++;
		else
			reqs_rejected++;
	endtask

	// Stop offering and wait for every pending report
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (delay_reports_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [pdmf_pkg::CFG_IDX_W-1:0] idx,
			input logic [pdmf_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pdmf_pkg::REG_PEER_MODE: mdl_peer = data[0];
			pdmf_pkg::REG_MAX_AGE:   mdl_max_age = data;
			default: ;
		endcase
		reg_writes++;
	endtask

	// Reset defaults, end-to-end formula: halving corners and timestamp extremes
	task automatic test_e2e_corners();
		send_exchange(stamps(64'd200, 64'd400, 64'd0, 64'd0, 64'd0, 64'd100, 32'd1000));
		send_exchange(stamps(64'd1, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 32'd1001));
		send_exchange(stamps(64'd2, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 32'd1002));
		send_exchange(stamps(64'd3, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 32'd1003));
		send_exchange(stamps(S64_MAX, S64_MAX, S64_MAX, S64_MAX, S64_MAX, S64_MAX,
			32'hFFFF_FFFF));
		send_exchange(stamps(S64_MIN, S64_MIN, S64_MIN, S64_MIN, S64_MIN, S64_MIN, 32'd0));
		send_exchange(stamps(64'd0, S64_MAX, ALL_ONES, ALL_ONES, S64_MIN, 64'd0, 32'd5));
		send_exchange(stamps(64'd0, S64_MIN, 64'd0, 64'd0, S64_MAX, 64'd0, 32'd6));
		send_exchange(stamps(S64_MIN, S64_MAX, 64'd0, 64'd0, 64'd0, 64'd0, 32'd7));
		send_exchange(stamps(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
			32'd8));
		send_exchange(stamps(64'd0, S64_MIN, 64'd0, 64'd0, 64'd0, 64'd0, 32'd9));
		send_exchange(stamps(64'd0, S64_MAX, 64'd0, 64'd0, 64'd0, 64'd0, 32'd10));
		wait_drain();
	endtask

	// Peer formula: wrap in the differences and the halving corners
	task automatic test_peer_corners();
		write_reg(pdmf_pkg::REG_PEER_MODE, pdmf_pkg::CFG_W'(1));
		send_exchange(stamps(64'd1000, 64'd5000, 64'd5600, 64'd2000, 64'd0, 64'd0, 32'd20));
		send_exchange(make_exchange(ALL_ONES, 32'd21));
		send_exchange(stamps(S64_MIN, 64'd7, 64'd7, S64_MAX, ALL_ONES, S64_MAX, 32'd22));
		send_exchange(make_exchange(S64_MIN, 32'd23));
		send_exchange(make_exchange(S64_MAX, 32'd24));
		wait_drain();
	endtask

	// Ages: zero window, equal times, wrap of the millisecond counter, widest window
	task automatic test_aging();
		write_reg(pdmf_pkg::REG_MAX_AGE, pdmf_pkg::CFG_W'(0));
		send_exchange(make_exchange(64'd600, 32'hFFFF_FFF0));
		send_exchange(make_exchange(64'd200, 32'hFFFF_FFF0));
		send_exchange(make_exchange(64'd400, 32'hFFFF_FFF0));
		send_exchange(make_exchange(64'd1000, 32'h0000_0010));
		wait_drain();
		write_reg(pdmf_pkg::REG_MAX_AGE, pdmf_pkg::CFG_W'(32'h20));
		send_exchange(make_exchange(64'd1800, 32'h0000_0010));
		wait_drain();
		write_reg(pdmf_pkg::REG_MAX_AGE, pdmf_pkg::CFG_W'(32'hFFFF_FFFF));
		send_exchange(make_exchange(64'd3000, 32'h8000_0000));
		wait_drain();
	endtask

	// Random traffic under one register setting
	task automatic test_random_phase(input bit peer, input logic [31:0] max_age,
			input int unsigned count, input int unsigned scale);
		exchange_t x;
		write_reg(pdmf_pkg::REG_PEER_MODE, pdmf_pkg::CFG_W'(peer));
		write_reg(pdmf_pkg::REG_MAX_AGE, max_age);
		repeat (count) begin
			if ($urandom_range(0, 9) == 0)
				x = stamps(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), next_ms(scale));
			else
				x = make_exchange(pick_numerator(), next_ms(scale));
			send_exchange(x);
		end
		wait_drain();
	endtask

	// Receiver holds off while requests keep coming, so the input side backs up
	task automatic test_long_stall();
		exchange_t x;
		write_reg(pdmf_pkg::REG_PEER_MODE, pdmf_pkg::CFG_W'(1));
		write_reg(pdmf_pkg::REG_MAX_AGE, pdmf_pkg::CFG_W'(5000));
		hold_token <= hold_token + 1;
		gaps_off   = 1'b1;
		burst_left = 0;
		repeat (40) begin
			x = make_exchange(pick_numerator(), next_ms(200));
			send_exchange(x);
		end
		gaps_off = 1'b0;
		wait_drain();
		test_random_phase(1'b1, 32'd5000, 160, 200);
	endtask

	// Result side: ready pattern steps through four modes, plus the long hold on request
	int unsigned rx_cycle;
	int unsigned hold_seen;
	int unsigned hold_left;
	always @(posedge clk) begin
		rx_cycle++;
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case ((rx_cycle >> 7) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (rx_cycle[2:0] != 3'd0);
			endcase
		end
	end

	// Compare each report with the oldest prediction
	always @(posedge clk) begin : report_check
		delay_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (delay_reports_q.size() == 0) begin
				$display("%0t: unexpected report: accepted %0d path_delay %0d delay_valid %0d",
					$time, accepted, path_delay, delay_valid);
				errors++;
			end else begin
				want = delay_reports_q.pop_front();
				reports_seen++;
				if (accepted !== want.accepted) begin
					$display("%0t: accepted expected %0d actual %0d",
						$time, want.accepted, accepted);
					errors++;
				end
				if (path_delay !== want.path_delay) begin
					$display("%0t: path_delay expected %0d actual %0d",
						$time, want.path_delay, path_delay);
					errors++;
				end
				if (delay_valid !== want.delay_valid) begin
					$display("%0t: delay_valid expected %0d actual %0d",
						$time, want.delay_valid, delay_valid);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any handshake
	int unsigned quiet_cycles;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d reports pending",
					$time, quiet_cycles, delay_reports_q.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= pdmf_pkg::REG_PEER_MODE;
		cfg_data         <= '0;
		in_valid         <= 1'b0;
		req_sent_local   <= '0;
		req_recv_remote  <= '0;
		resp_sent_remote <= '0;
		resp_recv_local  <= '0;
		sync_sent_master <= '0;
		sync_recv_local  <= '0;
		now_ms           <= '0;
		out_ready        <= 1'b0;
		ring_wr     = 0;
		ring_fill   = 0;
		filt_delay  = '0;
		filt_valid  = 1'b0;
		mdl_peer    = 1'b0;
		mdl_max_age = pdmf_pkg::MAX_AGE_RESET;
		burst_left  = 0;
		gaps_off    = 1'b0;
		cur_ms      = $urandom();
		hold_token  = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_e2e_corners();
		test_peer_corners();
		test_aging();
		test_random_phase(1'b0, pdmf_pkg::MAX_AGE_RESET, 250, 3000);
		test_random_phase(1'b1, 32'd0, 200, 3);
		test_random_phase(1'b1, 32'hFFFF_FFFF, 200, 32'h0010_0000);
		test_random_phase(1'b0, 32'($urandom_range(1, 40)), 200, 20);
		test_long_stall();
		test_random_phase(1'b0, $urandom(), 200, 32'h4000_0000);

		wait_drain();
		repeat (END_CYCLES) @(posedge clk);
		$display("Ran %0d requests (%0d stored, %0d rejected), %0d reports checked",
			reqs_sent, reqs_stored, reqs_rejected, reports_seen);
		$display("across %0d register writes: both formulas, age windows 0 to 2^32-1",
			reg_writes);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/pdmf_pkg.sv
rtl/core/pdmf_alu.sv
rtl/core/pdmf_ring.sv
rtl/core/ptp_path_delay_min_filter.sv
rtl/core/pdmf_checker.sv
bench/tb_ptp_path_delay_min_filter.sv
